// File: rtl/cst_pkg.sv
// Shared types, constants and character-class helpers for the source tokenizer.
// Used by cst_front, cst_queue, cst_back and cpp_source_tokenizer.
package cst_pkg;

   localparam int MAX_DELIM_LEN = 16;
   localparam int DLEN_W = $clog2(MAX_DELIM_LEN + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] OFF_MAX = 32'hFFFF_FFFF;
   localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;
   localparam logic [15:0] COL_MAX = 16'hFFFF;

   // token classes
   localparam logic [3:0] K_IDENT = 4'd0;
   localparam logic [3:0] K_NUMBER = 4'd1;
   localparam logic [3:0] K_STRING = 4'd2;
   localparam logic [3:0] K_RAW = 4'd3;
   localparam logic [3:0] K_CHAR = 4'd4;
   localparam logic [3:0] K_SYMBOL = 4'd5;
   localparam logic [3:0] K_DIRECTIVE = 4'd6;
   localparam logic [3:0] K_LINECOM = 4'd7;
   localparam logic [3:0] K_BLOCKCOM = 4'd8;
   localparam logic [3:0] K_ERROR = 4'd9;
   localparam logic [3:0] K_END = 4'd10;

   // error codes
   localparam logic [2:0] E_NONE = 3'd0;
   localparam logic [2:0] E_NO_PAREN = 3'd1;
   localparam logic [2:0] E_OPEN_RAW = 3'd2;
   localparam logic [2:0] E_OPEN_BLOCK = 3'd3;
   localparam logic [2:0] E_OPEN_STRING = 3'd4;
   localparam logic [2:0] E_OPEN_CHAR = 3'd5;
   localparam logic [2:0] E_UNKNOWN = 3'd6;

   // raw prefix tracker codes
   localparam logic [2:0] PFX_NONE = 3'd0;
   localparam logic [2:0] PFX_U = 3'd1;
   localparam logic [2:0] PFX_UL = 3'd2;
   localparam logic [2:0] PFX_U8 = 3'd3;
   localparam logic [2:0] PFX_FULL = 3'd4;

   // byte constants
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_DOT = 8'h2E;

   typedef struct packed {
      logic [31:0] off;
      logic [23:0] line;
      logic [15:0] col;
   } pos_type;

   typedef struct packed {
      logic [15:0] end_column;
      logic [23:0] end_line;
      logic [15:0] start_column;
      logic [23:0] start_line;
      logic [31:0] end_offset;
      logic [31:0] start_offset;
      logic [2:0]  error_code;
      logic [3:0]  token_kind;
   } res_type;

   // all results caused by one input transaction
   typedef struct packed {
      logic [1:0]        cnt;
      res_type [2:0]     res;
   } bundle_type;

   function automatic res_type mk_res(logic [3:0] kind, logic [2:0] err,
                                      pos_type s, pos_type e);
      res_type r;
      r.token_kind = kind;
      r.error_code = err;
      r.start_offset = s.off;
      r.end_offset = e.off;
      r.start_line = s.line;
      r.start_column = s.col;
      r.end_line = e.line;
      r.end_column = e.col;
      return r;
   endfunction

   function automatic bundle_type push_res(bundle_type b, res_type r);
      bundle_type o;
      o = b;
      o.res[b.cnt] = r;
      o.cnt = b.cnt + 2'd1;
      return o;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_long_start(logic [7:0] c);
      return c == 8'h2D || c == 8'h3A || c == 8'h2B || c == 8'h26 || c == 8'h7C ||
             c == 8'h2E || c == 8'h3D || c == 8'h21 || c == 8'h3C || c == 8'h3E ||
             c == 8'h2A || c == 8'h2F || c == 8'h5E;
   endfunction

   function automatic logic is_single(logic [7:0] c);
      return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D || c == 8'h7B ||
             c == 8'h7D || c == 8'h2C || c == 8'h3F || c == 8'h3B || c == 8'h7E ||
             c == 8'h25;
   endfunction

   // second byte that extends a one-byte symbol into a two-byte one
   function automatic logic is_pair(logic [7:0] p, logic [7:0] c);
      logic r;
      r = 1'b0;
      unique case (p)
         8'h2D: r = c == 8'h3E || c == 8'h2D || c == 8'h3D;
         8'h3A: r = c == 8'h3A;
         8'h2B: r = c == 8'h2B || c == 8'h3D;
         8'h26: r = c == 8'h26 || c == 8'h3D;
         8'h7C: r = c == 8'h7C || c == 8'h3D;
         8'h3D, 8'h21, 8'h3C, 8'h3E, 8'h2A, 8'h2F, 8'h5E: r = c == 8'h3D;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] prefix_next(logic [2:0] t, logic [7:0] c);
      logic [2:0] r;
      r = PFX_NONE;
      unique case (t)
         PFX_U: r = (c == 8'h38) ? PFX_U8 : ((c == 8'h52) ? PFX_FULL : PFX_NONE);
         PFX_UL, PFX_U8: r = (c == 8'h52) ? PFX_FULL : PFX_NONE;
         default: r = PFX_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat32(logic [31:0] v);
      return (v == OFF_MAX) ? v : v + 32'd1;
   endfunction

   function automatic logic [23:0] sat24(logic [23:0] v);
      return (v == LINE_MAX) ? v : v + 24'd1;
   endfunction

   function automatic logic [15:0] sat16(logic [15:0] v);
      return (v == COL_MAX) ? v : v + 16'd1;
   endfunction

endpackage

// File: rtl/cpp_source_tokenizer.sv
// Top level of the streaming source tokenizer: front lexer, bundle queue, back end.
// Depends on cst_pkg, cst_front, cst_queue and cst_back.
//
// Usage: source bytes enter on the req_ channel, one per transaction, with
// req_tuser set on the end-of-source transaction (its byte is ignored).
// Tokens leave on the rsp_ channel, tlast marking the last token caused by
// one input transaction; an input that closes no token gives nothing.
// Throughput: one byte per cycle while the queue has room. An input that
// causes n tokens (at most three) has them handed out one per cycle by the
// back end from the head of the queue, while rsp_tready is high.
// A token caused by a byte enters the queue when the byte is taken and is
// offered on rsp_ from its head; tokens that need lookahead appear with the
// following byte. The queue holds two bundles; when the receiver stalls it
// fills and req_tready drops, and nothing is lost or repeated.
// Reset (synchronous, active high) empties the queue and returns the lexer
// to between tokens at line 1, column 1, offset 0. The end marker returns the
// lexer to that state after its tokens; it does not empty the queue.
module cpp_source_tokenizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] source_byte
   input  logic         req_tuser,   // [0] end_marker
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // start_offset, end_offset, start_line, start_column,
                                     // end_line, end_column
   output logic [6:0]   rsp_tuser,   // [3:0] token_kind, [6:4] error_code
   output logic         rsp_tlast    // last_result
);
   import cst_pkg::*;

   logic       fire, push, not_full, not_empty, pop;
   bundle_type bundle, head;
   res_type    res;

   assign req_tready = not_full;
   assign fire = req_tvalid && req_tready;

   cst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .source_byte (req_tdata),
      .end_marker  (req_tuser),
      .push        (push),
      .bundle      (bundle)
   );

   cst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .not_full  (not_full),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop)
   );

   cst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .avail     (not_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (res),
      .out_last  (rsp_tlast)
   );

   // result packing
   assign rsp_tdata = {res.end_column, res.end_line, res.start_column, res.start_line,
                       res.end_offset, res.start_offset};
   assign rsp_tuser = {res.error_code, res.token_kind};

endmodule

// File: rtl/cst_front.sv
// Front end of the tokenizer: the lexer state machine, position counters and
// raw-string delimiter match; emits a bundle of results per transaction that has any. Uses cst_pkg.
module cst_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          source_byte,
   input  logic                end_marker,
   output logic                push,
   output cst_pkg::bundle_type bundle
);
   import cst_pkg::*;

   localparam logic [3:0] M_BETWEEN = 4'd0;
   localparam logic [3:0] M_IDENT = 4'd1;
   localparam logic [3:0] M_NUMBER = 4'd2;
   localparam logic [3:0] M_SYMBOL = 4'd3;
   localparam logic [3:0] M_DIRECTIVE = 4'd4;
   localparam logic [3:0] M_LINECOM = 4'd5;
   localparam logic [3:0] M_BLOCKCOM = 4'd6;
   localparam logic [3:0] M_STRING = 4'd7;
   localparam logic [3:0] M_CHAR = 4'd8;
   localparam logic [3:0] M_RAWDELIM = 4'd9;
   localparam logic [3:0] M_RAWBODY = 4'd10;

   logic [3:0]        mode_ff, mode_in;
   logic [7:0]        pend_ff, pend_in;
   logic [1:0]        pcnt_ff, pcnt_in;
   logic [2:0]        pfx_ff, pfx_in;
   logic [DLEN_W-1:0] dlen_ff, dlen_in;
   logic [1:0]        esc_ff, esc_in;
   logic              prev_cr_ff, prev_cr_in;
   logic              err_ff, err_in;
   pos_type           cur_ff, cur_in;
   pos_type           tok_ff, tok_in;
   // delimiter held newest byte first, so entry j lines up with tail entry j
   logic [7:0]        dref_ff [MAX_DELIM_LEN];
   logic [7:0]        dref_in [MAX_DELIM_LEN];
   logic [7:0]        tail_ff [MAX_DELIM_LEN+1];
   logic [7:0]        tail_in [MAX_DELIM_LEN+1];

   pos_type    np, bumped;
   logic       closes;
   logic       consumed;
   logic       do_start, do_flush;
   bundle_type b;
   logic [7:0] c;

   assign c = source_byte;

   // position just past the current byte
   always_comb begin
      np.off = sat32(cur_ff.off);
      np.line = cur_ff.line;
      np.col = cur_ff.col;
      if (c == CH_CR || (c == CH_LF && !prev_cr_ff)) begin
         np.line = sat24(cur_ff.line);
         np.col = 16'd1;
      end else if (c != CH_LF) begin
         np.col = sat16(cur_ff.col);
      end
      bumped.off = sat32(tok_ff.off);
      bumped.line = tok_ff.line;
      bumped.col = sat16(tok_ff.col);
   end

   // raw terminator: ')' then delimiter, all within the tail window
   always_comb begin
      closes = (tail_ff[dlen_ff] == CH_RPAREN);
      for (int j = 0; j < MAX_DELIM_LEN; j++) begin
         if (DLEN_W'(j) < dlen_ff && tail_ff[j] != dref_ff[j]) closes = 1'b0;
      end
   end

   // escape handling shared by strings, chars and line tokens
   always_comb begin
      consumed = 1'b0;
      if (esc_ff == 2'd2) consumed = (c == CH_LF);
      else if (esc_ff == 2'd1) consumed = 1'b1;
   end

   // lexer step
   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      pcnt_in = pcnt_ff;
      pfx_in = pfx_ff;
      dlen_in = dlen_ff;
      esc_in = esc_ff;
      prev_cr_in = prev_cr_ff;
      err_in = err_ff;
      cur_in = cur_ff;
      tok_in = tok_ff;
      dref_in = dref_ff;
      tail_in = tail_ff;
      b = '0;
      do_start = 1'b0;
      do_flush = 1'b0;
      if (fire && end_marker) begin
         if (!err_ff) begin
            unique case (mode_ff)
               M_IDENT: b = push_res(b, mk_res(K_IDENT, E_NONE, tok_ff, cur_ff));
               M_NUMBER: b = push_res(b, mk_res(K_NUMBER, E_NONE, tok_ff, cur_ff));
               M_SYMBOL: do_flush = 1'b1;
               M_DIRECTIVE: b = push_res(b, mk_res(K_DIRECTIVE, E_NONE, tok_ff, cur_ff));
               M_LINECOM: b = push_res(b, mk_res(K_LINECOM, E_NONE, tok_ff, cur_ff));
               M_BLOCKCOM: b = push_res(b, mk_res(K_ERROR, E_OPEN_BLOCK, tok_ff, cur_ff));
               M_STRING: b = push_res(b, mk_res(K_ERROR, E_OPEN_STRING, tok_ff, cur_ff));
               M_CHAR: b = push_res(b, mk_res(K_ERROR, E_OPEN_CHAR, tok_ff, cur_ff));
               M_RAWDELIM: b = push_res(b, mk_res(K_ERROR, E_NO_PAREN, tok_ff, cur_ff));
               M_RAWBODY: b = push_res(b, mk_res(K_ERROR, E_OPEN_RAW, tok_ff, cur_ff));
               default: ;
            endcase
            if (do_flush) begin
               if (pcnt_ff >= 2'd2) begin
                  b = push_res(b, mk_res(K_SYMBOL, E_NONE, tok_ff, bumped));
                  b = push_res(b, mk_res(K_SYMBOL, E_NONE, bumped, cur_ff));
               end else if (pcnt_ff == 2'd1) begin
                  b = push_res(b, mk_res(K_SYMBOL, E_NONE, tok_ff, cur_ff));
               end
            end
         end
         b = push_res(b, mk_res(K_END, E_NONE, cur_ff, cur_ff));
         // back to the reset state
         mode_in = M_BETWEEN;
         pend_in = '0;
         pcnt_in = '0;
         pfx_in = PFX_NONE;
         dlen_in = '0;
         esc_in = '0;
         prev_cr_in = 1'b0;
         err_in = 1'b0;
         cur_in = '{off: 32'd0, line: 24'd1, col: 16'd1};
         tok_in = '{off: 32'd0, line: 24'd1, col: 16'd1};
         for (int j = 0; j <= MAX_DELIM_LEN; j++) tail_in[j] = '0;
      end else if (fire && !err_ff) begin
         unique case (mode_ff)
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  pfx_in = prefix_next(pfx_ff, c);
               end else if (c == CH_DQUOTE && pfx_ff == PFX_FULL) begin
                  mode_in = M_RAWDELIM;
                  dlen_in = '0;
               end else begin
                  b = push_res(b, mk_res(K_IDENT, E_NONE, tok_ff, cur_ff));
                  do_start = 1'b1;
               end
            end
            M_NUMBER: begin
               if (!is_digit(c)) begin
                  b = push_res(b, mk_res(K_NUMBER, E_NONE, tok_ff, cur_ff));
                  do_start = 1'b1;
               end
            end
            M_SYMBOL: begin
               if (pcnt_ff == 2'd1 && pend_ff == CH_SLASH &&
                   (c == CH_SLASH || c == CH_STAR)) begin
                  mode_in = (c == CH_SLASH) ? M_LINECOM : M_BLOCKCOM;
                  esc_in = '0;
                  pcnt_in = '0;
               end else if (pcnt_ff == 2'd1 && pend_ff == CH_DOT && c == CH_DOT) begin
                  pcnt_in = 2'd2;
               end else if ((pcnt_ff == 2'd1 && is_pair(pend_ff, c)) ||
                            (pcnt_ff != 2'd1 && c == CH_DOT)) begin
                  b = push_res(b, mk_res(K_SYMBOL, E_NONE, tok_ff, np));
                  pcnt_in = '0;
                  mode_in = M_BETWEEN;
               end else begin
                  // two dots without a third give two one-dot symbols
                  if (pcnt_ff >= 2'd2) begin
                     b = push_res(b, mk_res(K_SYMBOL, E_NONE, tok_ff, bumped));
                     b = push_res(b, mk_res(K_SYMBOL, E_NONE, bumped, cur_ff));
                  end else if (pcnt_ff == 2'd1) begin
                     b = push_res(b, mk_res(K_SYMBOL, E_NONE, tok_ff, cur_ff));
                  end
                  pcnt_in = '0;
                  do_start = 1'b1;
               end
            end
            M_DIRECTIVE, M_LINECOM: begin
               if (esc_ff != 2'd0) begin
                  esc_in = (esc_ff == 2'd1 && c == CH_CR) ? 2'd2 : 2'd0;
               end
               if (!consumed) begin
                  if (c == CH_CR || c == CH_LF) begin
                     b = push_res(b, mk_res((mode_ff == M_DIRECTIVE) ? K_DIRECTIVE : K_LINECOM,
                                            E_NONE, tok_ff, cur_ff));
                     do_start = 1'b1;
                  end else if (c == CH_BSLASH) begin
                     esc_in = 2'd1;
                  end
               end
            end
            M_BLOCKCOM: begin
               if (esc_ff == 2'd1 && c == CH_SLASH) begin
                  b = push_res(b, mk_res(K_BLOCKCOM, E_NONE, tok_ff, np));
                  mode_in = M_BETWEEN;
                  esc_in = '0;
               end else begin
                  esc_in = (c == CH_STAR) ? 2'd1 : 2'd0;
               end
            end
            M_STRING, M_CHAR: begin
               if (esc_ff != 2'd0) begin
                  esc_in = (esc_ff == 2'd1 && c == CH_CR) ? 2'd2 : 2'd0;
               end
               if (!consumed) begin
                  if (c == CH_BSLASH) begin
                     esc_in = 2'd1;
                  end else if (c == ((mode_ff == M_STRING) ? CH_DQUOTE : CH_SQUOTE)) begin
                     b = push_res(b, mk_res((mode_ff == M_STRING) ? K_STRING : K_CHAR,
                                            E_NONE, tok_ff, np));
                     mode_in = M_BETWEEN;
                  end
               end
            end
            M_RAWDELIM: begin
               if (c == CH_LPAREN) begin
                  mode_in = M_RAWBODY;
                  for (int j = 0; j <= MAX_DELIM_LEN; j++) tail_in[j] = '0;
               end else if (dlen_ff >= DLEN_W'(MAX_DELIM_LEN)) begin
                  b = push_res(b, mk_res(K_ERROR, E_NO_PAREN, tok_ff, np));
                  err_in = 1'b1;
                  mode_in = M_BETWEEN;
                  pcnt_in = '0;
               end else begin
                  dref_in[0] = c;
                  for (int j = 1; j < MAX_DELIM_LEN; j++) dref_in[j] = dref_ff[j-1];
                  dlen_in = dlen_ff + 1'b1;
               end
            end
            M_RAWBODY: begin
               if (c == CH_DQUOTE && closes) begin
                  b = push_res(b, mk_res(K_RAW, E_NONE, tok_ff, np));
                  mode_in = M_BETWEEN;
               end else begin
                  tail_in[0] = c;
                  for (int j = 1; j <= MAX_DELIM_LEN; j++) tail_in[j] = tail_ff[j-1];
               end
            end
            default: do_start = 1'b1;
         endcase

         // start of a new token with this byte
         if (do_start) begin
            tok_in = cur_ff;
            mode_in = M_BETWEEN;
            esc_in = '0;
            priority if (is_space(c)) begin
            end else if (is_alpha(c)) begin
               mode_in = M_IDENT;
               pfx_in = (c == 8'h52) ? PFX_FULL :
                        ((c == 8'h75) ? PFX_U :
                         ((c == 8'h55 || c == 8'h4C) ? PFX_UL : PFX_NONE));
            end else if (is_digit(c)) begin
               mode_in = M_NUMBER;
            end else if (c == CH_DQUOTE) begin
               mode_in = M_STRING;
            end else if (c == CH_SQUOTE) begin
               mode_in = M_CHAR;
            end else if (c == CH_HASH) begin
               mode_in = M_DIRECTIVE;
            end else if (is_long_start(c)) begin
               mode_in = M_SYMBOL;
               pend_in = c;
               pcnt_in = 2'd1;
            end else if (is_single(c)) begin
               b = push_res(b, mk_res(K_SYMBOL, E_NONE, cur_ff, np));
            end else begin
               b = push_res(b, mk_res(K_ERROR, E_UNKNOWN, cur_ff, np));
               err_in = 1'b1;
               pcnt_in = '0;
            end
         end

         cur_in = np;
         prev_cr_in = (c == CH_CR);
      end
   end

   assign push = fire && (b.cnt != 2'd0);
   assign bundle = b;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_BETWEEN;
         pend_ff <= '0;
         pcnt_ff <= '0;
         pfx_ff <= PFX_NONE;
         dlen_ff <= '0;
         esc_ff <= '0;
         prev_cr_ff <= 1'b0;
         err_ff <= 1'b0;
         cur_ff <= '{off: 32'd0, line: 24'd1, col: 16'd1};
         tok_ff <= '{off: 32'd0, line: 24'd1, col: 16'd1};
         for (int j = 0; j <= MAX_DELIM_LEN; j++) tail_ff[j] <= '0;
      end else begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
         pfx_ff <= pfx_in;
         dlen_ff <= dlen_in;
         esc_ff <= esc_in;
         prev_cr_ff <= prev_cr_in;
         err_ff <= err_in;
         cur_ff <= cur_in;
         tok_ff <= tok_in;
         tail_ff <= tail_in;
      end
   end

   // delimiter bytes, only read once written
   always_ff @(posedge clock) begin
      dref_ff <= dref_in;
   end

   a_dlen_max: assert property (@(posedge clock) disable iff (reset)
      dlen_ff <= DLEN_W'(MAX_DELIM_LEN))
      else $error("delimiter length beyond maximum");
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      (err_ff && fire && !end_marker) |-> !push)
      else $error("result after latched error");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (fire && end_marker) |=> (!err_ff && mode_ff == M_BETWEEN))
      else $error("end marker did not return to idle");

endmodule

// File: rtl/cst_queue.sv
// Two-entry queue of result bundles between the lexer front and the output back.
// Uses cst_pkg.
module cst_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cst_pkg::bundle_type push_data,
   output logic                not_full,
   output logic                not_empty,
   output cst_pkg::bundle_type head,
   input  logic                pop
);
   import cst_pkg::*;

   bundle_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   rd_ff, rd_in, wr_ff, wr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign not_full = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head = mem_ff[rd_ff];

   // pointer and fill update
   always_comb begin
      rd_in = rd_ff;
      wr_in = wr_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop) rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (not_full || pop))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue underflow");
   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      not_empty |-> head.cnt != 2'd0)
      else $error("empty bundle queued");

endmodule

// File: rtl/cst_back.sv
// Back end: hands the results of the head bundle out one transaction at a time
// and marks the last one. Uses cst_pkg.
module cst_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                avail,
   input  cst_pkg::bundle_type head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output cst_pkg::res_type    out_res,
   output logic                out_last
);
   import cst_pkg::*;

   logic [1:0] idx_ff, idx_in;

   assign out_valid = avail;
   assign out_res = head.res[idx_ff];
   assign out_last = (idx_ff == head.cnt - 2'd1);
   assign pop = avail && out_ready && out_last;

   // walk through the bundle
   always_comb begin
      idx_in = idx_ff;
      if (avail && out_ready) idx_in = out_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for cpp_source_tokenizer: drives source bytes and
// end markers, predicts every token in a behavioural lexer, compares results.
// Depends on cst_pkg and the tokenizer RTL.
module testbench;
   import cst_pkg::*;

   localparam int ITEM_TARGET = 280;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [3:0] {
      LX_BETWEEN, LX_IDENT, LX_NUMBER, LX_SYMBOL, LX_DIRECTIVE, LX_LINECOM,
      LX_BLOCKCOM, LX_STRING, LX_CHAR, LX_RAWDELIM, LX_RAWBODY
   } lex_mode_type;

   typedef struct {
      logic [3:0] kind;
      logic [2:0] err;
      pos_type    s;
      pos_type    e;
      logic       last;
   } token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'd0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic [6:0] rsp_tuser;
   logic rsp_tlast;

   cpp_source_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // lexer state of the predictor
   lex_mode_type mode;
   logic [7:0]  sym_first;
   int          sym_count;
   logic [2:0]  prefix;
   logic [7:0]  delim [MAX_DELIM_LEN];
   int          delim_len;
   logic [7:0]  tail [MAX_DELIM_LEN + 1];
   int          esc;
   logic        prev_cr;
   pos_type     cur, tok;
   logic        latched;

   token_type   step_tokens[$];
   token_type   expected_tokens[$];
   logic [8:0]  source_items[$];

   int n_items_total = 0;
   int n_accepted = 0;
   int n_mismatch = 0;
   int n_cycles = 0;
   logic long_hold = 1'b0;

   function automatic logic c_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic c_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic c_space(logic [7:0] c);
      return c == " " || c == 8'h09 || c == CH_LF || c == 8'h0B || c == 8'h0C || c == CH_CR;
   endfunction

   function automatic logic c_long(logic [7:0] c);
      return c == "-" || c == ":" || c == "+" || c == "&" || c == "|" || c == "." ||
             c == "=" || c == "!" || c == "<" || c == ">" || c == "*" || c == "/" ||
             c == "^";
   endfunction

   function automatic logic c_single(logic [7:0] c);
      return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}" ||
             c == "," || c == "?" || c == ";" || c == "~" || c == "%";
   endfunction

   function automatic logic c_pair(logic [7:0] p, logic [7:0] c);
      case (p)
         "-": return c == ">" || c == "-" || c == "=";
         ":": return c == ":";
         "+": return c == "+" || c == "=";
         "&": return c == "&" || c == "=";
         "|": return c == "|" || c == "=";
         "=", "!", "<", ">", "*", "/", "^": return c == "=";
         default: return 1'b0;
      endcase
   endfunction

   function automatic pos_type bump(pos_type p);
      pos_type r;
      r = p;
      if (r.off != OFF_MAX) r.off = r.off + 1;
      if (r.col != COL_MAX) r.col = r.col + 1;
      return r;
   endfunction

   function automatic void clear_lexer();
      mode = LX_BETWEEN;
      sym_first = 8'd0;
      sym_count = 0;
      prefix = PFX_NONE;
      for (int i = 0; i < MAX_DELIM_LEN; i++) delim[i] = 8'd0;
      delim_len = 0;
      for (int i = 0; i <= MAX_DELIM_LEN; i++) tail[i] = 8'd0;
      esc = 0;
      prev_cr = 1'b0;
      cur = '{off: 32'd0, line: 24'd1, col: 16'd1};
      tok = cur;
      latched = 1'b0;
   endfunction

   function automatic void add_token(logic [3:0] k, logic [2:0] e, pos_type s, pos_type f);
      token_type t;
      if (step_tokens.size() >= 3) return;
      t.kind = k; t.err = e; t.s = s; t.e = f; t.last = 1'b0;
      step_tokens.push_back(t);
   endfunction

   function automatic void lex_error(logic [2:0] code, pos_type s, pos_type f);
      add_token(K_ERROR, code, s, f);
      latched = 1'b1;
      mode = LX_BETWEEN;
      sym_count = 0;
   endfunction

   function automatic void open_token(logic [7:0] c, pos_type np);
      tok = cur;
      mode = LX_BETWEEN;
      esc = 0;
      if (c_space(c)) return;
      if (c_alpha(c)) begin
         mode = LX_IDENT;
         prefix = (c == "R") ? PFX_FULL : (c == "u") ? PFX_U :
                  (c == "U" || c == "L") ? PFX_UL : PFX_NONE;
      end else if (c_digit(c)) begin
         mode = LX_NUMBER;
      end else if (c == CH_DQUOTE) begin
         mode = LX_STRING;
      end else if (c == CH_SQUOTE) begin
         mode = LX_CHAR;
      end else if (c == CH_HASH) begin
         mode = LX_DIRECTIVE;
      end else if (c_long(c)) begin
         mode = LX_SYMBOL;
         sym_first = c;
         sym_count = 1;
      end else if (c_single(c)) begin
         add_token(K_SYMBOL, E_NONE, cur, np);
      end else begin
         lex_error(E_UNKNOWN, cur, np);
      end
   endfunction

   function automatic void flush_symbols();
      if (sym_count >= 2) begin
         add_token(K_SYMBOL, E_NONE, tok, bump(tok));
         add_token(K_SYMBOL, E_NONE, bump(tok), cur);
      end else if (sym_count == 1) begin
         add_token(K_SYMBOL, E_NONE, tok, cur);
      end
      sym_count = 0;
      mode = LX_BETWEEN;
   endfunction

   function automatic logic raw_closes();
      if (delim_len > MAX_DELIM_LEN || tail[delim_len] != CH_RPAREN) return 1'b0;
      for (int i = 0; i < delim_len; i++)
         if (tail[delim_len - 1 - i] != delim[i]) return 1'b0;
      return 1'b1;
   endfunction

   // true when the byte is swallowed by a backslash escape
   function automatic logic escaped(logic [7:0] c);
      if (esc == 2) begin
         esc = 0;
         return c == CH_LF;
      end
      if (esc == 1) begin
         esc = (c == CH_CR) ? 2 : 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void lex_byte(logic [7:0] c, pos_type np);
      case (mode)
         LX_IDENT: begin
            if (c_alpha(c) || c_digit(c)) begin
               case (prefix)
                  PFX_U: prefix = (c == "8") ? PFX_U8 : (c == "R") ? PFX_FULL : PFX_NONE;
                  PFX_UL, PFX_U8: prefix = (c == "R") ? PFX_FULL : PFX_NONE;
                  default: prefix = PFX_NONE;
               endcase
            end else if (c == CH_DQUOTE && prefix == PFX_FULL) begin
               mode = LX_RAWDELIM;
               delim_len = 0;
            end else begin
               add_token(K_IDENT, E_NONE, tok, cur);
               open_token(c, np);
            end
         end
         LX_NUMBER: begin
            if (!c_digit(c)) begin
               add_token(K_NUMBER, E_NONE, tok, cur);
               open_token(c, np);
            end
         end
         LX_SYMBOL: begin
            if (sym_count == 1 && sym_first == CH_SLASH && (c == CH_SLASH || c == CH_STAR)) begin
               mode = (c == CH_SLASH) ? LX_LINECOM : LX_BLOCKCOM;
               esc = 0;
               sym_count = 0;
            end else if (sym_count == 1 && sym_first == CH_DOT && c == CH_DOT) begin
               sym_count = 2;
            end else if ((sym_count == 1 && c_pair(sym_first, c)) ||
                         (sym_count != 1 && c == CH_DOT)) begin
               add_token(K_SYMBOL, E_NONE, tok, np);
               sym_count = 0;
               mode = LX_BETWEEN;
            end else begin
               flush_symbols();
               open_token(c, np);
            end
         end
         LX_DIRECTIVE, LX_LINECOM: begin
            if (!escaped(c)) begin
               if (c == CH_CR || c == CH_LF) begin
                  add_token(mode == LX_DIRECTIVE ? K_DIRECTIVE : K_LINECOM, E_NONE, tok, cur);
                  open_token(c, np);
               end else if (c == CH_BSLASH) begin
                  esc = 1;
               end
            end
         end
         LX_BLOCKCOM: begin
            if (esc == 1 && c == CH_SLASH) begin
               add_token(K_BLOCKCOM, E_NONE, tok, np);
               mode = LX_BETWEEN;
               esc = 0;
            end else begin
               esc = (c == CH_STAR) ? 1 : 0;
            end
         end
         LX_STRING, LX_CHAR: begin
            if (!escaped(c)) begin
               if (c == CH_BSLASH) begin
                  esc = 1;
               end else if (c == (mode == LX_STRING ? CH_DQUOTE : CH_SQUOTE)) begin
                  add_token(mode == LX_STRING ? K_STRING : K_CHAR, E_NONE, tok, np);
                  mode = LX_BETWEEN;
               end
            end
         end
         LX_RAWDELIM: begin
            if (c == CH_LPAREN) begin
               mode = LX_RAWBODY;
               for (int i = 0; i <= MAX_DELIM_LEN; i++) tail[i] = 8'd0;
            end else if (delim_len >= MAX_DELIM_LEN) begin
               lex_error(E_NO_PAREN, tok, np);
            end else begin
               delim[delim_len] = c;
               delim_len++;
            end
         end
         LX_RAWBODY: begin
            if (c == CH_DQUOTE && raw_closes()) begin
               add_token(K_RAW, E_NONE, tok, np);
               mode = LX_BETWEEN;
            end else begin
               for (int i = MAX_DELIM_LEN; i > 0; i--) tail[i] = tail[i - 1];
               tail[0] = c;
            end
         end
         default: open_token(c, np);
      endcase
   endfunction

   function automatic void flush_at_end();
      case (mode)
         LX_IDENT: add_token(K_IDENT, E_NONE, tok, cur);
         LX_NUMBER: add_token(K_NUMBER, E_NONE, tok, cur);
         LX_SYMBOL: flush_symbols();
         LX_DIRECTIVE: add_token(K_DIRECTIVE, E_NONE, tok, cur);
         LX_LINECOM: add_token(K_LINECOM, E_NONE, tok, cur);
         LX_BLOCKCOM: add_token(K_ERROR, E_OPEN_BLOCK, tok, cur);
         LX_STRING: add_token(K_ERROR, E_OPEN_STRING, tok, cur);
         LX_CHAR: add_token(K_ERROR, E_OPEN_CHAR, tok, cur);
         LX_RAWDELIM: add_token(K_ERROR, E_NO_PAREN, tok, cur);
         LX_RAWBODY: add_token(K_ERROR, E_OPEN_RAW, tok, cur);
         default: ;
      endcase
   endfunction

   // predict the tokens caused by one accepted transaction
   function automatic void predict_tokens(logic [7:0] c, logic end_mark);
      pos_type np;
      step_tokens.delete();
      if (end_mark) begin
         if (!latched) flush_at_end();
         add_token(K_END, E_NONE, cur, cur);
         clear_lexer();
      end else if (!latched) begin
         np = cur;
         if (np.off != OFF_MAX) np.off = np.off + 1;
         if (c == CH_CR || (c == CH_LF && !prev_cr)) begin
            if (np.line != LINE_MAX) np.line = np.line + 1;
            np.col = 16'd1;
         end else if (c != CH_LF) begin
            if (np.col != COL_MAX) np.col = np.col + 1;
         end
         lex_byte(c, np);
         cur = np;
         prev_cr = (c == CH_CR);
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endfunction

   // stimulus helpers
   task automatic add_byte(logic [7:0] b);
      source_items.push_back({1'b0, b});
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_end();
      source_items.push_back({1'b1, 8'($urandom)});
   endtask

   function automatic logic [7:0] body_byte();
      case ($urandom_range(0, 11))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_BSLASH;
         3: return CH_STAR;
         4: return CH_RPAREN;
         5: return " ";
         default: return 8'($urandom_range(8'h20, 8'h7E));
      endcase
   endfunction

   function automatic logic [7:0] word_byte(logic first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   task automatic add_random_token();
      string syms [14];
      logic [7:0] dl [$];
      int n;
      syms = '{"->", "...", "..", "::", "<=", "&&", "||", "++", "-=", "^", "%", "{", "/=", ";"};
      case ($urandom_range(0, 15))
         0, 1: begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_byte(word_byte(i == 0));
         end
         2: begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(0, 9)));
         end
         3: begin
            add_byte(CH_DQUOTE);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               add_byte(body_byte());
               if ($urandom_range(0, 3) == 0) add_byte(CH_DQUOTE);
            end
            add_byte(CH_DQUOTE);
         end
         4: begin
            add_byte(CH_SQUOTE);
            if ($urandom_range(0, 2) == 0) add_byte(CH_BSLASH);
            add_byte(body_byte());
            add_byte(CH_SQUOTE);
         end
         5, 6: begin
            case ($urandom_range(0, 4))
               0: add_text("R");
               1: add_text("u8R");
               2: add_text("uR");
               3: add_text("UR");
               default: add_text("LR");
            endcase
            add_byte(CH_DQUOTE);
            n = ($urandom_range(0, 20) == 0) ? MAX_DELIM_LEN + 1 : $urandom_range(0, 3);
            for (int i = 0; i < n; i++) dl.push_back(8'("a" + $urandom_range(0, 2)));
            foreach (dl[i]) add_byte(dl[i]);
            add_byte(CH_LPAREN);
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 3))
                  0: add_byte(CH_RPAREN);
                  1: add_byte(CH_DQUOTE);
                  2: add_byte(dl.size() > 0 ? dl[0] : "a");
                  default: add_byte(body_byte());
               endcase
            end
            add_byte(CH_RPAREN);
            foreach (dl[i]) add_byte(dl[i]);
            add_byte(CH_DQUOTE);
         end
         7, 8: add_text(syms[$urandom_range(0, 13)]);
         9: begin
            add_text("#x");
            if ($urandom_range(0, 1)) add_text("\\\r\n y");
            add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
         end
         10: begin
            add_text("//");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) add_byte(body_byte());
            add_byte(CH_LF);
         end
         11: begin
            add_text("/*");
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) add_byte(body_byte());
            add_text("*/");
         end
         12, 13: begin
            case ($urandom_range(0, 5))
               0: add_byte(CH_CR);
               1: add_byte(CH_LF);
               2: add_text("\r\n");
               3: add_byte(8'h09);
               4: add_byte(8'h0B);
               default: add_byte(" ");
            endcase
         end
         14: add_byte(8'($urandom_range(0, 255)));
         default: begin
            if ($urandom_range(0, 5) == 0) add_byte(8'($urandom_range(8'h80, 8'hFF)));
            else add_byte(" ");
         end
      endcase
      if ($urandom_range(0, 1)) add_byte(" ");
   endtask

   // driver: new byte offered at the falling edge once the last one was taken
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
            // hold the current transaction
         end else if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (source_items.size() > 0) begin
            {req_tuser, req_tdata} <= source_items.pop_front();
            req_tvalid <= 1'b1;
            req_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stall before each result, plus one long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) rsp_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
         if (long_hold) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      wait (n_accepted >= 100);
      long_hold = 1'b1;
      repeat (300) @(posedge clock);
      long_hold = 1'b0;
   end

   // monitor: predict on input transactions, check output transactions
   always @(posedge clock) begin
      token_type t;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            predict_tokens(req_tdata, req_tuser);
            n_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected token: kind %0d tdata %h", rsp_tuser[3:0], rsp_tdata);
            end else begin
               t = expected_tokens.pop_front();
               if (rsp_tuser[3:0] !== t.kind || rsp_tuser[6:4] !== t.err ||
                   rsp_tdata[31:0] !== t.s.off || rsp_tdata[63:32] !== t.e.off ||
                   rsp_tdata[87:64] !== t.s.line || rsp_tdata[103:88] !== t.s.col ||
                   rsp_tdata[127:104] !== t.e.line || rsp_tdata[143:128] !== t.e.col ||
                   rsp_tlast !== t.last) begin
                  n_mismatch++;
                  if (n_mismatch <= 10) begin
                     $display("token mismatch: exp kind %0d err %0d off %0d-%0d pos %0d:%0d-%0d:%0d last %b",
                              t.kind, t.err, t.s.off, t.e.off, t.s.line, t.s.col,
                              t.e.line, t.e.col, t.last);
                     $display("                got kind %0d err %0d off %0d-%0d pos %0d:%0d-%0d:%0d last %b",
                              rsp_tuser[3:0], rsp_tuser[6:4],
                              rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[87:64],
                              rsp_tdata[103:88], rsp_tdata[127:104], rsp_tdata[143:128],
                              rsp_tlast);
                  end
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int n_random;
      clear_lexer();
      // directed: raw strings, long symbols, escapes, comments, errors
      add_text("uR\"b(q)b)b\" a->b...c..d");
      add_end();
      add_text("//c\\\r\nx\r\n#d\n/*/ */'\\''");
      add_end();
      add_text("u8R\"(\")\" \"s\\\"\"");
      add_end();
      add_text("R\"aaaaaaaaaaaaaaaaa");
      add_end();
      add_byte(8'hFF);
      add_text("x");
      add_end();
      add_text("/*");
      add_end();
      // random source text, ended every few dozen bytes
      n_random = 0;
      while (n_random < ITEM_TARGET) begin
         int before_n;
         before_n = source_items.size();
         add_random_token();
         if ($urandom_range(0, 25) == 0) add_end();
         n_random += source_items.size() - before_n;
      end
      add_end();
      n_items_total = source_items.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (n_accepted == n_items_total);
      wait (expected_tokens.size() == 0);
      repeat (30) @(posedge clock);
      if (n_mismatch == 0 && expected_tokens.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
